// ===== sv/assert_macros.svh =====
// Assertion macros used by the controller of the ICMP error message builder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, disabled while rst_n is low
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset
`define ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== sv/iemb_pkg.sv =====
// Shared types, sizes and codes of the ICMP error message builder
package iemb_pkg;

    // Quoted part of the offending datagram
    localparam int HEADER_BYTES  = 20;
    localparam int TRAILER_BYTES = 8;
    localparam int STORE_BYTES   = HEADER_BYTES + TRAILER_BYTES;
    // Type, code, checksum, pointer and three pad bytes
    localparam int PREFIX_BYTES  = 8;
    localparam int MSG_BYTES     = PREFIX_BYTES + STORE_BYTES;

    localparam int STORE_IDX_W = $clog2(STORE_BYTES);
    localparam int TAKEN_W     = $clog2(STORE_BYTES + 1);
    localparam int MSG_IDX_W   = $clog2(MSG_BYTES);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // Item kinds carried on tuser
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    // Byte positions within the emitted message
    localparam logic [MSG_IDX_W-1:0] POS_TYPE  = MSG_IDX_W'(0);
    localparam logic [MSG_IDX_W-1:0] POS_CODE  = MSG_IDX_W'(1);
    localparam logic [MSG_IDX_W-1:0] POS_CK_HI = MSG_IDX_W'(2);
    localparam logic [MSG_IDX_W-1:0] POS_CK_LO = MSG_IDX_W'(3);
    localparam logic [MSG_IDX_W-1:0] POS_PTR   = MSG_IDX_W'(4);
    localparam logic [MSG_IDX_W-1:0] POS_PAD0  = MSG_IDX_W'(5);
    localparam logic [MSG_IDX_W-1:0] POS_PAD1  = MSG_IDX_W'(6);
    localparam logic [MSG_IDX_W-1:0] POS_PAD2  = MSG_IDX_W'(7);
    localparam logic [MSG_IDX_W-1:0] POS_LAST  = MSG_IDX_W'(MSG_BYTES - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 take;   // input transfer completes this cycle
        logic                 load;   // load the output register
        logic [MSG_IDX_W-1:0] idx;    // message byte to load
    } iemb_cmd_t;

endpackage

// ===== sv/iemb_ctrl.sv =====
// Controller of the ICMP error message builder: accepts items and sequences emission
`include "assert_macros.svh"

module iemb_ctrl
    import iemb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output iemb_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [MSG_IDX_W-1:0]  cnt_reg, cnt_next;
    logic                  ovalid_reg, ovalid_next;
    logic                  accept;
    logic                  load;

    // Handshake decode
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == S_EMIT) && (!ovalid_reg || m_tready);
    assign m_tvalid = ovalid_reg;

    assign cmd.take = accept;
    assign cmd.load = load;
    assign cmd.idx  = cnt_reg;

    // Next state and byte counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && s_tlast)
                begin
                    state_next = S_EMIT;
                    cnt_next   = '0;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    cnt_next = cnt_reg + MSG_IDX_W'(1);
                    if (cnt_reg == POS_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once the held byte is taken
    always_comb
    begin
        if (load)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // An end mark starts emission from the first message byte
    `ASSERT_CLK(a_end_starts_emit, (accept && s_tlast) |=> (state_reg == S_EMIT && cnt_reg == '0), "end mark did not start emission")
    // Loading the final byte returns the controller to idle
    `ASSERT_CLK(a_last_ends_emit, (load && cnt_reg == POS_LAST) |=> (state_reg == S_IDLE), "emission did not end after final byte")
    // The counter stays within the message while emitting
    `ASSERT_NEVER(a_cnt_range, (state_reg == S_EMIT) && (cnt_reg > POS_LAST), "byte counter beyond message")

endmodule

// ===== sv/iemb_dpath.sv =====
// Datapath of the ICMP error message builder: held header, quote store, checksum, output register
module iemb_dpath
    import iemb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  iemb_cmd_t            cmd,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic [M_TDATA_W-1:0] out_byte,
    output logic                 out_last
);

    logic [7:0]             type_reg;
    logic [7:0]             code_reg;
    logic [7:0]             ptr_reg;
    logic [15:0]            sum_reg, sum_next;
    logic [TAKEN_W-1:0]     taken_reg;
    logic [7:0]             store_reg [STORE_BYTES];
    logic [M_TDATA_W-1:0]   obyte_reg;
    logic                   olast_reg;

    logic [7:0]             in_type;
    logic [7:0]             in_code;
    logic [7:0]             in_ptr;
    logic [7:0]             in_byte;
    logic                   room;
    logic [15:0]            word;
    logic [15:0]            cksum;
    logic [MSG_IDX_W-1:0]   spos;
    logic                   from_store;
    logic [7:0]             sel_byte;

    // Ones-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    // Unpack the input transfer
    assign in_type = s_tdata[7:0];
    assign in_code = s_tdata[15:8];
    assign in_ptr  = s_tdata[23:16];
    assign in_byte = s_tdata[31:24];

    assign room = (taken_reg < TAKEN_W'(STORE_BYTES));
    // Even store positions are high bytes of a message word
    assign word = taken_reg[0] ? {8'h00, in_byte} : {in_byte, 8'h00};

    // Running checksum sum
    always_comb
    begin
        if (s_tuser == CMD_HEADER)
        begin
            sum_next = ones_add({in_type, in_code}, {in_ptr, 8'h00});
        end
        else
        begin
            sum_next = ones_add(sum_reg, word);
        end
    end

    // Hold header fields, fill count and sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg  <= '0;
            code_reg  <= '0;
            ptr_reg   <= '0;
            sum_reg   <= '0;
            taken_reg <= '0;
        end
        else if (cmd.take)
        begin
            if (s_tuser == CMD_HEADER)
            begin
                type_reg  <= in_type;
                code_reg  <= in_code;
                ptr_reg   <= in_ptr;
                sum_reg   <= sum_next;
                taken_reg <= '0;
            end
            else if (room)
            begin
                sum_reg   <= sum_next;
                taken_reg <= taken_reg + TAKEN_W'(1);
            end
        end
    end

    // Write quoted bytes in arrival order; unfilled entries read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.take && s_tuser == CMD_DATA && room)
        begin
            store_reg[taken_reg[STORE_IDX_W-1:0]] <= in_byte;
        end
    end

    assign cksum      = ~sum_reg;
    assign spos       = cmd.idx - MSG_IDX_W'(PREFIX_BYTES);
    assign from_store = (cmd.idx > POS_PAD2) && (spos < MSG_IDX_W'(taken_reg));

    // Select the prefix byte at the current position
    always_comb
    begin
        case (cmd.idx) inside
            POS_TYPE:  sel_byte = type_reg;
            POS_CODE:  sel_byte = code_reg;
            POS_CK_HI: sel_byte = cksum[15:8];
            POS_CK_LO: sel_byte = cksum[7:0];
            POS_PTR:   sel_byte = ptr_reg;
            POS_PAD0, POS_PAD1, POS_PAD2:
                       sel_byte = 8'h00;
            default:   sel_byte = 8'h00;
        endcase
    end

    // Output register, loaded from the store or from the prefix select
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (from_store)
            begin
                obyte_reg <= store_reg[spos[STORE_IDX_W-1:0]];
            end
            else
            begin
                obyte_reg <= sel_byte;
            end
            olast_reg <= (cmd.idx == POS_LAST);
        end
    end

    assign out_byte = obyte_reg;
    assign out_last = olast_reg;

endmodule

// ===== sv/icmp_error_message_builder_top.sv =====
// An end mark starts emission, which loads message bytes into the output register.
// Items without end mark are accepted back to back while idle. Emission sends the
// 36-byte message, one byte per cycle from the output register while m_tready is high.
// s_tready stays low during emission, which is paced by the single byte counter.
// Reset (rst_n, asynchronous, active low) clears held fields, checksum and fill count.
module icmp_error_message_builder_top
    import iemb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // msg_type, msg_code, error_pointer, data_byte
    input  logic                 s_tuser,   // cmd
    input  logic                 s_tlast,   // data_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_byte
    output logic                 m_tlast    // out_last
);

    iemb_cmd_t cmd;

    // Sequence accepts and emission
    iemb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Hold state and build message bytes
    iemb_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_byte (m_tdata),
        .out_last (m_tlast)
    );

endmodule
